// ===== design/sbs_pkg.sv =====
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared types and constants of the wildcard byte signature scanner.
// ----------------------------------------------------------------------------
package sbs_pkg;

  localparam int MaxSigLen  = 48;
  localparam int WinDepth   = MaxSigLen - 1;
  localparam int SigRegs    = 6;
  localparam int SigRegW    = 64;
  localparam int LenBits    = 6;
  localparam int OffsetBits = 32;
  localparam int CfgIdxW    = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSig0  = 3'd0,
    CfgSig1  = 3'd1,
    CfgSig2  = 3'd2,
    CfgSig3  = 3'd3,
    CfgSig4  = 3'd4,
    CfgSig5  = 3'd5,
    CfgWild  = 3'd6,
    CfgLen   = 3'd7
  } cfg_idx_e;

  // Signature right-aligned to the newest byte: entry j is compared with the
  // byte that arrived j items before the current one.
  typedef struct packed {
    logic [MaxSigLen-1:0][7:0] sig;
    logic [MaxSigLen-1:0]      care;
    logic [LenBits-1:0]        len;
  } sbs_cfg_t;

  typedef struct packed {
    logic                  produced;
    logic                  found;
    logic [OffsetBits-1:0] offset;
  } sbs_hit_t;

endpackage

// ===== design/wildcard_byte_signature_scanner.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scanner
// Scans byte regions for a signature with per-position wildcards.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one byte per item (data_byte_i) with region_last_i set on
//   the final byte of a region. Output channel: at most one item per region,
//   found_o with match_offset_o (offset of the first matched byte, zero when
//   not found). Both channels use valid/stall; an item moves when valid is
//   high and stall is low.
//   Throughput is one byte per cycle while the receiver does not stall:
//   every signature position is compared against the byte window in
//   parallel, between the input register and the result register. A byte's
//   result, if any, becomes valid in the result register after the input register.
//   Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i while
//   the block is idle; the aligned compare image follows in the next cycle.
//   Reset clears the signature, wildcard mask, length (to one), the window
//   and the region count; no clearing pass is needed.
//   While the receiver stalls, the result holds and one more byte can wait
//   in the input register; after that in_stall_o is raised.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scanner import sbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [SigRegW-1:0]    cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  region_last_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  found_o,
  output logic [OffsetBits-1:0] match_offset_o
);

  sbs_cfg_t              cfg;
  sbs_hit_t              hit;
  logic                  in_valid_q;
  logic [7:0]            byte_q;
  logic                  last_q;
  logic                  out_valid_q;
  logic                  found_q;
  logic [OffsetBits-1:0] offset_q;
  logic                  advance;
  logic                  accept;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  sbs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sbs_match u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .byte_i (byte_q),
    .last_i (last_q),
    .cfg_i  (cfg),
    .hit_o  (hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
      last_q <= region_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && hit.produced) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && hit.produced) begin
      found_q  <= hit.found;
      offset_q <= hit.offset;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = offset_q;

endmodule

// ===== design/sbs_cfg.sv =====
// ----------------------------------------------------------------------------
// sbs_cfg
// Configuration registers and the aligned compare image derived from them.
// ----------------------------------------------------------------------------
module sbs_cfg import sbs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [SigRegW-1:0]   cfg_data_i,
  output sbs_cfg_t             cfg_o
);

  logic [SigRegs-1:0][SigRegW-1:0] sig_q;
  logic [MaxSigLen-1:0]            wild_q;
  logic [LenBits-1:0]              len_q;
  logic [LenBits-1:0]              len_eff;
  sbs_cfg_t                        cfg_d, cfg_q;
  logic [MaxSigLen-1:0][7:0]       sig_bytes;

  assign sig_bytes = sig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q  <= '0;
      wild_q <= '0;
      len_q  <= LenBits'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgSig0, CfgSig1, CfgSig2, CfgSig3, CfgSig4, CfgSig5: begin
          sig_q[cfg_index_i] <= cfg_data_i;
        end
        CfgWild: wild_q <= cfg_data_i[MaxSigLen-1:0];
        CfgLen:  len_q  <= cfg_data_i[LenBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_eff = len_q;
    if (len_q == '0) begin
      len_eff = LenBits'(1);
    end else if (len_q > LenBits'(MaxSigLen)) begin
      len_eff = LenBits'(MaxSigLen);
    end
  end

  // Reverse the used part of the signature so that its last position lines
  // up with the newest byte; positions past the length are don't-care.
  always_comb begin
    logic [LenBits-1:0] src;
    cfg_d     = '0;
    cfg_d.len = len_eff;
    for (int j = 0; j < MaxSigLen; j++) begin
      src = len_eff - LenBits'(j) - LenBits'(1);
      if (LenBits'(j) < len_eff) begin
        cfg_d.sig[j]  = sig_bytes[src];
        cfg_d.care[j] = !wild_q[src];
      end
    end
  end

  // The reset image is a one-byte signature of zero with no wildcard.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{sig: '0, care: MaxSigLen'(1), len: LenBits'(1)};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/sbs_match.sv =====
// ----------------------------------------------------------------------------
// sbs_match
// Byte window, region byte count and the parallel signature compare.
// ----------------------------------------------------------------------------
module sbs_match import sbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  sbs_cfg_t   cfg_i,
  output sbs_hit_t   hit_o
);

  logic [WinDepth-1:0][7:0] window_q, window_d;
  logic [OffsetBits-1:0]    seen_q, seen_n;
  logic                     reported_q;
  logic [OffsetBits-1:0]    len_ext;
  logic                     all_ok;
  logic                     enough;
  logic                     hit;

  // Saturating count including the current byte.
  assign seen_n  = (seen_q != '1) ? seen_q + OffsetBits'(1) : seen_q;
  assign len_ext = OffsetBits'(cfg_i.len);
  assign enough  = (seen_n >= len_ext);

  always_comb begin
    all_ok = !cfg_i.care[0] || (byte_i == cfg_i.sig[0]);
    for (int j = 1; j < MaxSigLen; j++) begin
      if (cfg_i.care[j] && (window_q[j-1] != cfg_i.sig[j])) begin
        all_ok = 1'b0;
      end
    end
  end

  assign hit = !reported_q && enough && all_ok;

  always_comb begin
    hit_o          = '0;
    hit_o.produced = hit || (!reported_q && last_i);
    hit_o.found    = hit;
    if (hit) begin
      hit_o.offset = seen_n - len_ext;
    end
  end

  always_comb begin
    window_d[0] = byte_i;
    for (int k = 1; k < WinDepth; k++) begin
      window_d[k] = window_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= '0;
      seen_q     <= '0;
      reported_q <= 1'b0;
    end else if (fire_i) begin
      if (last_i) begin
        window_q   <= '0;
        seen_q     <= '0;
        reported_q <= 1'b0;
      end else begin
        window_q   <= window_d;
        seen_q     <= seen_n;
        reported_q <= reported_q || hit;
      end
    end
  end

endmodule

// ===== design/sbs_checker.sv =====
// ----------------------------------------------------------------------------
// sbs_checker
// Port-level checks of the signature scanner, bound to the top level.
// ----------------------------------------------------------------------------
module sbs_checker import sbs_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [7:0]            data_byte_i,
  input logic                  region_last_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic                  found_o,
  input logic [OffsetBits-1:0] match_offset_o
);

  // A stalled input item stays offered and keeps its payload.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=>
      in_valid_i && $stable(data_byte_i) && $stable(region_last_i))
    else $error("input item changed while stalled");

  // A stalled result item stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(found_o) && $stable(match_offset_o))
    else $error("result item changed while stalled");

  // A not-found item always carries a zero offset.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> match_offset_o == '0)
    else $error("not-found item with nonzero offset");

  // The input side only stalls when a result is waiting on a stalled receiver.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without downstream back-pressure");

endmodule

bind wildcard_byte_signature_scanner sbs_checker u_sbs_checker (.*);

// ===== tb/sbs_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// sbs_tb_pkg
// Scoreboard for the wildcard byte signature scanner. It mirrors the scan
// state, predicts the found/not-found item of every region and checks the
// items that the block delivers.
// ----------------------------------------------------------------------------
package sbs_tb_pkg;
  import sbs_pkg::*;

  typedef struct packed {
    logic                  found;
    logic [OffsetBits-1:0] offset;
  } scan_report_t;

  class scan_scoreboard;
    logic [SigRegW-1:0]    sig_regs [SigRegs];
    logic [MaxSigLen-1:0]  wild;
    logic [LenBits-1:0]    len_reg;
    logic [7:0]            window [WinDepth];
    logic [OffsetBits-1:0] seen;
    logic                  reported;
    scan_report_t          expected_reports [$];
    int                    mismatches;
    int                    found_cnt;
    int                    not_found_cnt;
    int                    regions;

    function new();
      foreach (sig_regs[r]) sig_regs[r] = '0;
      wild          = '0;
      len_reg       = 1;
      mismatches    = 0;
      found_cnt     = 0;
      not_found_cnt = 0;
      regions       = 0;
      clear_region();
    endfunction

    function void clear_region();
      foreach (window[k]) window[k] = 8'h00;
      seen     = '0;
      reported = 1'b0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [SigRegW-1:0] value);
      case (idx)
        CfgWild: wild = value[MaxSigLen-1:0];
        CfgLen:  len_reg = value[LenBits-1:0];
        default: sig_regs[int'(idx)] = value;
      endcase
    endfunction

    function int eff_len();
      int l;
      l = int'(len_reg);
      if (l == 0) l = 1;
      if (l > MaxSigLen) l = MaxSigLen;
      return l;
    endfunction

    function logic [7:0] sig_byte(int pos);
      return sig_regs[pos / 8][(pos % 8) * 8 +: 8];
    endfunction

    function bit is_wild(int pos);
      return wild[pos];
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // Called for every accepted byte; queues the item the byte causes, if any.
    function void predict_byte(logic [7:0] b, logic last);
      logic [OffsetBits-1:0] n;
      logic [7:0]            v;
      int                    l;
      bit                    hit;
      bit                    produced;
      n = (seen == '1) ? seen : seen + 1'b1;
      produced = 1'b0;
      if (!reported) begin
        l = eff_len();
        if (n >= l) begin
          hit = 1'b1;
          for (int i = 0; i < l; i++) begin
            // Position l-1 lines up with the current byte, older ones with the window.
            v = (i == l - 1) ? b : window[l - 2 - i];
            if (!wild[i] && v != sig_byte(i)) hit = 1'b0;
          end
          if (hit) begin
            reported = 1'b1;
            produced = 1'b1;
            expected_reports.push_back('{found: 1'b1, offset: OffsetBits'(n - l)});
          end
        end
        if (!produced && last) expected_reports.push_back('{found: 1'b0, offset: '0});
      end
      if (last) begin
        clear_region();
        regions++;
      end else begin
        for (int k = WinDepth - 1; k > 0; k--) window[k] = window[k - 1];
        window[0] = b;
        seen = n;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_report(logic found, logic [OffsetBits-1:0] offset);
      scan_report_t exp_r;
      if (expected_reports.size() == 0) begin
        report($sformatf("unexpected item found=%0b offset=%0d", found, offset));
        return;
      end
      exp_r = expected_reports.pop_front();
      if (found !== exp_r.found)
        report($sformatf("found is %0b, predicted %0b", found, exp_r.found));
      if (offset !== exp_r.offset)
        report($sformatf("match_offset is %0d, predicted %0d", offset, exp_r.offset));
      if (exp_r.found) found_cnt++;
      else not_found_cnt++;
    endtask

    task check_drained();
      if (expected_reports.size() != 0)
        report($sformatf("%0d predicted items never arrived", expected_reports.size()));
    endtask
  endclass

endpackage

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wildcard byte signature scanner. A directed
// opening covers the reset signature, one-byte and wildcard-first patterns,
// regions too short to match and matches on the last byte; then randomly
// configured phases feed planted, damaged, truncated and noise regions with
// random gaps and output stalls, checked item by item by the scoreboard.
// ----------------------------------------------------------------------------
module tb;
  import sbs_pkg::*;
  import sbs_tb_pkg::*;

  typedef logic [7:0] byte_q_t [$];

  localparam int RandomItems = 930;
  localparam int PhaseItems  = 95;
  localparam int LongHold    = 120;
  localparam int NumLens     = 13;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CfgIdxW-1:0]    cfg_index_i;
  logic [SigRegW-1:0]    cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [7:0]            data_byte_i;
  logic                  region_last_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  found_o;
  logic [OffsetBits-1:0] match_offset_o;

  scan_scoreboard sb;
  int             bytes_sent;
  int             settings_used;
  bit             tx_quiet;
  bit             rx_quiet;
  bit             long_hold_req;

  wildcard_byte_signature_scanner u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .region_last_i  (region_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .match_offset_o (match_offset_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_report(found_o, match_offset_o);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // Half of the filler bytes are drawn from the signature to provoke partial matches.
  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 1) == 0) return 8'($urandom);
    return sb.sig_byte($urandom_range(0, MaxSigLen - 1));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    region_last_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.predict_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_region(input byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic wait_idle(input int settle);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [SigRegW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    sb.set_reg(idx, value);
    @(negedge clk_i);
  endtask

  // The compare image is registered from the configuration registers, so wait for it.
  task automatic end_writes();
    cfg_we_i <= 1'b0;
    repeat (2) @(negedge clk_i);
    settings_used++;
  endtask

  task automatic apply_setting(input int len_val, input int mask_mode);
    logic [SigRegW-1:0] v;
    wait_idle(6);
    for (int r = 0; r < SigRegs; r++) write_reg(cfg_idx_e'(int'(CfgSig0) + r), {$urandom, $urandom});
    // Bits above the register width carry random junk that must be dropped.
    v = {$urandom, $urandom};
    case (mask_mode)
      0:       v[MaxSigLen-1:0] = '0;
      1:       v[MaxSigLen-1:0] = '1;
      2:       v[MaxSigLen-1:0] = MaxSigLen'({$urandom & $urandom & $urandom,
                                              $urandom & $urandom});
      default: v[MaxSigLen-1:0] = MaxSigLen'({$urandom, $urandom});
    endcase
    write_reg(CfgWild, v);
    v = {$urandom, $urandom};
    v[LenBits-1:0] = len_val[LenBits-1:0];
    write_reg(CfgLen, v);
    end_writes();
  endtask

  task automatic make_region(output byte_q_t q);
    int kind;
    int len;
    int pre;
    int post;
    int pos;
    q = {};
    len = sb.eff_len();
    kind = $urandom_range(0, 99);
    pre = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 5);
    post = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
    repeat (pre) q.push_back(noise_byte());
    if (kind < 80) begin
      for (int i = 0; i < len; i++) q.push_back(sb.is_wild(i) ? 8'($urandom) : sb.sig_byte(i));
      if (kind >= 70) begin
        // Cut the signature short so that the region ends first.
        repeat ($urandom_range(1, len)) void'(q.pop_back());
        post = 0;
      end else if (kind >= 60) begin
        pos = pre + $urandom_range(0, len - 1);
        q[pos] = ~q[pos];
      end
      repeat (post) q.push_back(noise_byte());
    end else begin
      repeat ($urandom_range(1, 12)) q.push_back(noise_byte());
    end
    if (q.size() == 0) q.push_back(noise_byte());
  endtask

  initial begin : receiver
    int n;
    out_stall_i = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(negedge clk_i);
      end else if (rx_quiet || $urandom_range(0, 1) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end else begin
        n = pick_gap();
        out_stall_i <= (n != 0);
        repeat ((n == 0) ? 1 : n) @(negedge clk_i);
      end
    end
  end

  initial begin : limit
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : main
    int      phase_lens [NumLens] = '{48, 1, 63, 2, 5, 0, 16, 33, 8, 47, 3, 24, 40};
    int      phase;
    int      phase_start;
    bit      paused;
    byte_q_t q;
    sb            = new();
    bytes_sent    = 0;
    settings_used = 0;
    tx_quiet      = 1'b0;
    rx_quiet      = 1'b0;
    long_hold_req = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CfgSig0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    data_byte_i   = 8'h00;
    region_last_i = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset signature is a single zero byte: one-byte matches, including on
    // the last byte, a miss, and bytes after a match that must be ignored.
    send_region({8'h00});
    send_region({8'hFF});
    send_region({8'h12, 8'h00, 8'h00});

    // Four-byte signature with a wildcard in front.
    apply_setting(4, 0);
    write_reg(CfgSig0, {$urandom, 32'h4443_4241});
    write_reg(CfgWild, 64'h1);
    end_writes();
    send_region({8'h99, 8'h42});
    send_region({8'h43, 8'h44});
    send_region({8'h77, 8'h42, 8'h43, 8'h44});
    send_region({8'h01, 8'h02, 8'h42, 8'h43, 8'h44, 8'hFF, 8'h42});

    // A length of zero behaves as a single position.
    wait_idle(6);
    write_reg(CfgSig0, {$urandom, 24'($urandom), 8'hFF});
    write_reg(CfgWild, 64'h0);
    write_reg(CfgLen, 64'h0);
    end_writes();
    send_region({8'hFF});
    send_region({8'h00, 8'hFE});

    phase = 0;
    while (bytes_sent < RandomItems + 20) begin
      apply_setting(phase_lens[phase % NumLens], phase % 4);
      rx_quiet = ($urandom_range(0, 3) == 0);
      phase_start = bytes_sent;
      paused = 1'b0;
      if (phase == 2) begin
        // Results pile up behind a long output stall until the input backs up.
        rx_quiet = 1'b0;
        long_hold_req = 1'b1;
        tx_quiet = 1'b1;
        repeat (12) begin
          q = {};
          repeat ($urandom_range(1, 3)) q.push_back(noise_byte());
          send_region(q);
        end
      end
      while (bytes_sent - phase_start < PhaseItems) begin
        make_region(q);
        tx_quiet = ($urandom_range(0, 4) == 0);
        send_region(q);
        if (!paused && bytes_sent - phase_start >= PhaseItems / 2) begin
          wait_idle(1);
          paused = 1'b1;
        end
      end
      phase++;
    end

    wait_idle(10);
    sb.check_drained();
    $display("Scanned %0d bytes in %0d regions under %0d signature settings.",
             bytes_sent, sb.regions, settings_used);
    $display("Checked %0d found and %0d not-found items, %0d mismatches.",
             sb.found_cnt, sb.not_found_cnt, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sbs_pkg.sv
design/sbs_cfg.sv
design/sbs_match.sv
design/wildcard_byte_signature_scanner.sv
design/sbs_checker.sv
tb/sbs_tb_pkg.sv
tb/tb.sv
